// ===== rtl/core/fomm_pkg.sv =====
// ---------------------------------------------------------------------------
// Field-oriented mecanum mixer package
// Shared constants, tables, pipeline stage types and helper functions.
// ---------------------------------------------------------------------------
package fomm_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STEPS  = 16;
  localparam int ANGLE_LEN     = 24;
  localparam int CORDIC_EFF    = (CORDIC_STEPS > ANGLE_LEN) ? ANGLE_LEN : CORDIC_STEPS;
  localparam int SQRT_STEPS    = 16;
  localparam int LOOP_STAGES   = (CORDIC_EFF > SQRT_STEPS) ? CORDIC_EFF : SQRT_STEPS;
  localparam int QUO_BITS      = 17;

  // One turn is 23040 units = 512 * 45.
  localparam int TURN_DIV      = 45;
  localparam int RECIP_DIV     = 5825;   // slightly below 2^18 / 45
  localparam int RECIP_SHIFT   = 18;
  localparam int HEAD_OFFSET   = 16425;  // 365 * 45, makes the turn count positive

  // Rounded-up 2^34 / 45; with a shift of 34 - 23 it gives r * 2^23 / 45
  // exactly for every remainder below 45.
  localparam logic [28:0] FRAC_RECIP = 29'd381774871;
  localparam int          FRAC_SHIFT = 11;

  localparam logic signed [33:0] GAIN_Q30      = 34'sd652032874;
  localparam logic [29:0]        INV_SQRT2_Q30 = 30'd759250125;

  localparam int ONE_VAL = 1 << FRAC_BITS;
  localparam int OUT_LIM = (ONE_VAL > 32767) ? 32767 : ONE_VAL;

  localparam logic [31:0] ANGLE_STEPS [ANGLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
    logic [31:0]        rem;
    logic [33:0]        res;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] tn;
    logic               rot;
  } loop_t;

  typedef struct packed {
    logic [39:0]        r;
    logic [16:0]        q;
    logic               neg;
    logic signed [19:0] w;
  } div_lane_t;

  // Fractional part of the binary angle for a remainder below 45.
  function automatic logic [22:0] frac_angle(input logic [5:0] r);
    logic [34:0] t;
    t = 35'(r) * 35'(FRAC_RECIP);
    return 23'(t >> FRAC_SHIFT);
  endfunction

  // Shift right by 30 with rounding to nearest, halves away from zero.
  function automatic logic signed [51:0] round_q30(input logic signed [51:0] v);
    logic signed [51:0] half;
    logic signed [51:0] mag;
    half = 52'sd1 <<< 29;
    if (v >= 0) begin
      return (v + half) >>> 30;
    end
    mag = -v;
    return -((mag + half) >>> 30);
  endfunction

endpackage

// ===== rtl/core/field_oriented_mecanum_mixer_unit.sv =====
// ---------------------------------------------------------------------------
// Field-oriented mecanum mixer
// Rotates the stick vector by the gyro heading and mixes four wheel commands.
// ---------------------------------------------------------------------------
// A command is taken in every cycle that start is high; busy never rises. The
// result appears on the wheel ports with done high for one cycle. The pipeline
// holds the CORDIC and square root stages, one iteration per stage, and the
// restoring divider that normalizes the wheels, one quotient bit per stage.
// The receiver must take each result in its cycle. The field_oriented register
// is written through cfg_valid and cfg_data, always ready, and is to be
// changed only while no command is in flight.
module field_oriented_mecanum_mixer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] strafe,
  input  logic signed [15:0] forward,
  input  logic signed [15:0] turn,
  input  logic signed [23:0] heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               done,
  output logic signed [15:0] left_front,
  output logic signed [15:0] left_rear,
  output logic signed [15:0] right_front,
  output logic signed [15:0] right_rear
);

  localparam int LOOP    = fomm_pkg::LOOP_STAGES;
  localparam int QB      = fomm_pkg::QUO_BITS;
  localparam int LATENCY = 11 + LOOP + QB;

  logic field_oriented;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_oriented <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      field_oriented <= cfg_data;
    end
  end

  // Input capture.
  logic               v_s0;
  logic signed [15:0] rx_s0, ry_s0, tn_s0;
  logic signed [23:0] hd_s0;
  logic               rot_s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
    end else begin
      v_s0 <= start && !busy;
    end
    rx_s0  <= strafe;
    ry_s0  <= forward;
    tn_s0  <= turn;
    hd_s0  <= heading;
    rot_s0 <= field_oriented && ((strafe != '0) || (forward != '0));
  end

  // Heading reduction, step 1: estimate the turn count modulo 45.
  logic               v_s1;
  logic [15:0]        hu_s1;
  logic [10:0]        q_s1;
  logic [8:0]         low_s1;
  logic [31:0]        n_s1;
  logic signed [15:0] rx_s1, ry_s1, tn_s1;
  logic               rot_s1;
  logic [15:0]        hu_c;
  logic [28:0]        hq_c;
  logic signed [31:0] sqx_c, sqy_c;

  always_comb begin
    hu_c  = 16'(signed'({hd_s0[23], hd_s0[23:9]}) + 16'(fomm_pkg::HEAD_OFFSET));
    hq_c  = 29'(hu_c) * 29'(fomm_pkg::RECIP_DIV);
    sqx_c = rx_s0 * rx_s0;
    sqy_c = ry_s0 * ry_s0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else begin
      v_s1 <= v_s0;
    end
    hu_s1  <= hu_c;
    q_s1   <= 11'(hq_c >> fomm_pkg::RECIP_SHIFT);
    low_s1 <= hd_s0[8:0];
    n_s1   <= 32'(sqx_c) + 32'(sqy_c);
    rx_s1  <= rx_s0;
    ry_s1  <= ry_s0;
    tn_s1  <= tn_s0;
    rot_s1 <= rot_s0;
  end

  // Step 2: correct the remainder and form the heading within one turn.
  logic               v_s2;
  logic [14:0]        wr_s2;
  logic [31:0]        n_s2;
  logic signed [15:0] rx_s2, ry_s2, tn_s2;
  logic               rot_s2;
  logic [6:0]         r1_c;
  logic [5:0]         m1_c;

  always_comb begin
    r1_c = 7'(hu_s1 - 16'(q_s1 * 11'(fomm_pkg::TURN_DIV)));
    if (r1_c >= 7'(fomm_pkg::TURN_DIV)) begin
      m1_c = 6'(r1_c - 7'(fomm_pkg::TURN_DIV));
    end else begin
      m1_c = 6'(r1_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s2 <= 1'b0;
    end else begin
      v_s2 <= v_s1;
    end
    wr_s2  <= {m1_c, low_s1};
    n_s2   <= n_s1;
    rx_s2  <= rx_s1;
    ry_s2  <= ry_s1;
    tn_s2  <= tn_s1;
    rot_s2 <= rot_s1;
  end

  // Step 3: estimate the heading divided by 45.
  logic               v_s3;
  logic [14:0]        wr_s3;
  logic [9:0]         q_s3;
  logic [31:0]        n_s3;
  logic signed [15:0] rx_s3, ry_s3, tn_s3;
  logic               rot_s3;
  logic [27:0]        wq_c;

  assign wq_c = 28'(wr_s2) * 28'(fomm_pkg::RECIP_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s3 <= 1'b0;
    end else begin
      v_s3 <= v_s2;
    end
    wr_s3  <= wr_s2;
    q_s3   <= 10'(wq_c >> fomm_pkg::RECIP_SHIFT);
    n_s3   <= n_s2;
    rx_s3  <= rx_s2;
    ry_s3  <= ry_s2;
    tn_s3  <= tn_s2;
    rot_s3 <= rot_s2;
  end

  // Step 4: binary angle, then the CORDIC and square root pipeline.
  logic [6:0]         r2_c;
  logic [5:0]         m2_c;
  logic [9:0]         q2_c;
  logic [31:0]        ang_c;

  always_comb begin
    r2_c = 7'(wr_s3 - 15'(q_s3 * 10'(fomm_pkg::TURN_DIV)));
    if (r2_c >= 7'(fomm_pkg::TURN_DIV)) begin
      m2_c = 6'(r2_c - 7'(fomm_pkg::TURN_DIV));
      q2_c = q_s3 + 10'd1;
    end else begin
      m2_c = 6'(r2_c);
      q2_c = q_s3;
    end
    ang_c = {q2_c[8:0], fomm_pkg::frac_angle(m2_c)};
  end

  fomm_pkg::loop_t loop_q   [LOOP+1];
  fomm_pkg::loop_t loop_nxt [LOOP];
  logic            loop_v   [LOOP+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_v[0] <= 1'b0;
    end else begin
      loop_v[0] <= v_s3;
    end
    loop_q[0].x    <= fomm_pkg::GAIN_Q30;
    loop_q[0].y    <= '0;
    loop_q[0].z    <= 33'({3'b000, ang_c[29:0]});
    loop_q[0].quad <= ang_c[31:30];
    loop_q[0].rem  <= n_s3;
    loop_q[0].res  <= '0;
    loop_q[0].rx   <= rx_s3;
    loop_q[0].ry   <= ry_s3;
    loop_q[0].tn   <= tn_s3;
    loop_q[0].rot  <= rot_s3;
  end

  for (genvar gi = 0; gi < LOOP; gi++) begin : g_loop
    localparam int SQ_SHIFT = 2 * (fomm_pkg::SQRT_STEPS - 1) - 2 * gi;
    localparam logic [33:0] SQ_BIT = (SQ_SHIFT >= 0) ? (34'd1 << SQ_SHIFT) : 34'd0;
    localparam int ANG_IDX = (gi < fomm_pkg::ANGLE_LEN) ? gi : 0;

    logic signed [33:0] dx, dy;
    logic signed [32:0] da;
    logic [33:0]        trial;

    always_comb begin
      loop_nxt[gi] = loop_q[gi];
      dx    = loop_q[gi].y >>> gi;
      dy    = loop_q[gi].x >>> gi;
      da    = signed'({1'b0, fomm_pkg::ANGLE_STEPS[ANG_IDX]});
      trial = loop_q[gi].res + SQ_BIT;
      if (gi < fomm_pkg::CORDIC_EFF) begin
        if (!loop_q[gi].z[32]) begin
          loop_nxt[gi].x = loop_q[gi].x - dx;
          loop_nxt[gi].y = loop_q[gi].y + dy;
          loop_nxt[gi].z = loop_q[gi].z - da;
        end else begin
          loop_nxt[gi].x = loop_q[gi].x + dx;
          loop_nxt[gi].y = loop_q[gi].y - dy;
          loop_nxt[gi].z = loop_q[gi].z + da;
        end
      end
      if (gi < fomm_pkg::SQRT_STEPS) begin
        if (34'(loop_q[gi].rem) >= trial) begin
          loop_nxt[gi].rem = 32'(34'(loop_q[gi].rem) - trial);
          loop_nxt[gi].res = (loop_q[gi].res >> 1) + SQ_BIT;
        end else begin
          loop_nxt[gi].res = loop_q[gi].res >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        loop_v[gi+1] <= 1'b0;
      end else begin
        loop_v[gi+1] <= loop_v[gi];
      end
      loop_q[gi+1] <= loop_nxt[gi];
    end
  end

  // Quadrant fix-up and the rotation products.
  logic               v_p0;
  logic signed [49:0] pxc_p0, pys_p0, pyc_p0, pxs_p0;
  logic [16:0]        mag_p0;
  logic signed [15:0] rx_p0, ry_p0, tn_p0;
  logic               rot_p0;
  logic signed [33:0] cc, ss;
  fomm_pkg::loop_t    lf;

  always_comb begin
    lf = loop_q[LOOP];
    case (lf.quad)
      2'd0: begin
        cc = lf.x;
        ss = lf.y;
      end
      2'd1: begin
        cc = -lf.y;
        ss = lf.x;
      end
      2'd2: begin
        cc = -lf.x;
        ss = -lf.y;
      end
      default: begin
        cc = lf.y;
        ss = -lf.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p0 <= 1'b0;
    end else begin
      v_p0 <= loop_v[LOOP];
    end
    pxc_p0 <= 50'(lf.rx) * 50'(cc);
    pys_p0 <= 50'(lf.ry) * 50'(ss);
    pyc_p0 <= 50'(lf.ry) * 50'(cc);
    pxs_p0 <= 50'(lf.rx) * 50'(ss);
    // Round the square root to nearest.
    mag_p0 <= 17'(lf.res) + ((34'(lf.rem) > lf.res) ? 17'd1 : 17'd0);
    rx_p0  <= lf.rx;
    ry_p0  <= lf.ry;
    tn_p0  <= lf.tn;
    rot_p0 <= lf.rot;
  end

  // Rotated vector, or the stick vector as it is.
  logic               v_p1;
  logic signed [19:0] nx_p1, ny_p1, tn_p1;
  logic [16:0]        mag_p1;
  logic signed [51:0] rnx_c, rny_c;

  always_comb begin
    rnx_c = fomm_pkg::round_q30(52'(pxc_p0) - 52'(pys_p0));
    rny_c = fomm_pkg::round_q30(52'(pyc_p0) + 52'(pxs_p0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1 <= 1'b0;
    end else begin
      v_p1 <= v_p0;
    end
    nx_p1  <= rot_p0 ? 20'(rnx_c) : 20'(rx_p0);
    ny_p1  <= rot_p0 ? 20'(rny_c) : 20'(ry_p0);
    tn_p1  <= 20'(tn_p0);
    mag_p1 <= mag_p0;
  end

  // Wheel mix and magnitudes.
  logic               v_p2;
  logic signed [19:0] w_p2 [4];
  logic [17:0]        a_p2 [4];
  logic [16:0]        mag_p2;
  logic signed [19:0] w_c  [4];

  always_comb begin
    w_c[0] = ny_p1 + tn_p1 + nx_p1;
    w_c[1] = ny_p1 + tn_p1 - nx_p1;
    w_c[2] = -ny_p1 + tn_p1 + nx_p1;
    w_c[3] = -ny_p1 + tn_p1 - nx_p1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p2 <= 1'b0;
    end else begin
      v_p2 <= v_p1;
    end
    for (int k = 0; k < 4; k++) begin
      w_p2[k] <= w_c[k];
      a_p2[k] <= w_c[k][19] ? 18'(-w_c[k]) : 18'(w_c[k]);
    end
    mag_p2 <= mag_p1;
  end

  // Largest magnitude and the scale factor mag / sqrt 2.
  logic               v_p3;
  logic signed [19:0] w_p3 [4];
  logic [17:0]        m_p3;
  logic [16:0]        ms_p3;
  logic               need_p3;
  logic [17:0]        m01_c, m23_c, max_c;
  logic [46:0]        msp_c;

  always_comb begin
    m01_c = (a_p2[0] > a_p2[1]) ? a_p2[0] : a_p2[1];
    m23_c = (a_p2[2] > a_p2[3]) ? a_p2[2] : a_p2[3];
    max_c = (m01_c > m23_c) ? m01_c : m23_c;
    msp_c = 47'(mag_p2) * 47'(fomm_pkg::INV_SQRT2_Q30) + (47'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p3 <= 1'b0;
    end else begin
      v_p3 <= v_p2;
    end
    for (int k = 0; k < 4; k++) begin
      w_p3[k] <= w_p2[k];
    end
    m_p3    <= max_c;
    ms_p3   <= 17'(msp_c >> 30);
    need_p3 <= max_c > 18'(fomm_pkg::ONE_VAL);
  end

  // Restoring divider, one quotient bit per stage, four lanes.
  fomm_pkg::div_lane_t div_q [QB+1][4];
  logic                div_v [QB+1];
  logic [17:0]         div_m [QB+1];
  logic                div_need [QB+1];
  logic signed [37:0]  num_c [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num_c[k] = 38'(w_p3[k]) * 38'(signed'({1'b0, ms_p3}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else begin
      div_v[0] <= v_p3;
    end
    for (int k = 0; k < 4; k++) begin
      div_q[0][k].r   <= (num_c[k][37] ? 40'(-num_c[k]) : 40'(num_c[k])) + 40'(m_p3 >> 1);
      div_q[0][k].q   <= '0;
      div_q[0][k].neg <= num_c[k][37];
      div_q[0][k].w   <= w_p3[k];
    end
    div_m[0]    <= m_p3;
    div_need[0] <= need_p3;
  end

  for (genvar gd = 0; gd < QB; gd++) begin : g_div
    localparam int QPOS = QB - 1 - gd;
    logic [39:0]         dsh;
    fomm_pkg::div_lane_t dnx [4];

    assign dsh = 40'(div_m[gd]) << QPOS;

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        dnx[k] = div_q[gd][k];
        if (div_q[gd][k].r >= dsh) begin
          dnx[k].r       = div_q[gd][k].r - dsh;
          dnx[k].q[QPOS] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[gd+1] <= 1'b0;
      end else begin
        div_v[gd+1] <= div_v[gd];
      end
      for (int k = 0; k < 4; k++) begin
        div_q[gd+1][k] <= dnx[k];
      end
      div_m[gd+1]    <= div_m[gd];
      div_need[gd+1] <= div_need[gd];
    end
  end

  // Sign, selection and saturation into the output registers.
  logic signed [19:0] sel_c [4];
  logic signed [15:0] sat_c [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (div_need[QB]) begin
        sel_c[k] = div_q[QB][k].neg ? -20'(div_q[QB][k].q) : 20'(div_q[QB][k].q);
      end else begin
        sel_c[k] = div_q[QB][k].w;
      end
      if (sel_c[k] > 20'(fomm_pkg::OUT_LIM)) begin
        sat_c[k] = 16'(fomm_pkg::OUT_LIM);
      end else if (sel_c[k] < -20'(fomm_pkg::OUT_LIM)) begin
        sat_c[k] = -16'(fomm_pkg::OUT_LIM);
      end else begin
        sat_c[k] = 16'(sel_c[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_v[QB];
    end
    left_front  <= sat_c[0];
    left_rear   <= sat_c[1];
    right_front <= sat_c[2];
    right_rear  <= sat_c[3];
  end

  // Every result traces back to exactly one accepted request.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching request");

  a_turn_reduced: assert property (@(posedge clk) disable iff (rst)
    v_s2 |-> (wr_s2 < 15'd23040))
    else $error("heading reduction left the turn range");

  a_wheels_limited: assert property (@(posedge clk) disable iff (rst)
    done |-> (left_front <= 16'(fomm_pkg::OUT_LIM)) && (left_front >= -16'(fomm_pkg::OUT_LIM))
          && (right_rear <= 16'(fomm_pkg::OUT_LIM)) && (right_rear >= -16'(fomm_pkg::OUT_LIM)))
    else $error("wheel output beyond full scale");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    (div_v[QB] && div_need[QB]) |-> (div_q[QB][0].r < 40'(div_m[QB])))
    else $error("divider remainder not below the divisor");

endmodule
